// ----- src/fkos_pkg.sv -----
// shared constants and request/response types for the fenwick rank search unit
// no dependencies; used by fenwick_kth_order_statistic_unit and its testbench
package fkos_pkg;

   localparam int MAX_SIZE  = 4096;
   localparam int TOP_LEVEL = 12;

   localparam int SIZE_W  = 13;   // csr size_in_use width
   localparam int RANK_W  = 16;
   localparam int DELTA_W = 16;
   localparam int FOUND_W = 13;
   localparam int SUM_W   = 32;

   localparam int ADDR_W  = $clog2(MAX_SIZE);
   localparam int POS_W   = $clog2(MAX_SIZE + 1);
   localparam int LEVEL_W = $clog2(TOP_LEVEL + 1);
   // wide enough for positions up to twice the size and for a raw request index
   localparam int CMP_W   = (POS_W + 1 > RANK_W) ? POS_W + 1 : RANK_W;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_FIND = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic [RANK_W-1:0]         index_or_rank;
      logic signed [DELTA_W-1:0] delta;
   } req_item_type;

   typedef struct packed {
      logic [FOUND_W-1:0] found_position;
      logic               beyond_total;
   } rsp_item_type;

endpackage

// ----- src/fkos_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module fkos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fenwick_kth_order_statistic_unit.sv -----
// fenwick tree of counts with k-th element search, sequencer around one tree ram
// depends on fkos_pkg and fkos_ram
//
// Usage: a request is taken at a clock edge where start is high and busy is low.
// req_item.req_type selects add (delta into one position) or find (first position
// whose prefix sum reaches the rank). Adds give no response. Each find gives one
// response on rsp_item, marked by rsp_strobe for a single cycle; the receiver
// cannot stall it and must take it in that cycle.
// Add: a read-modify-write per tree level touched, the write of one level
// overlapped with the read of the next level; an index of 0 or above the size
// is dropped at once.
// Find: the descent visits levels TOP_LEVEL down to 0; a level that falls inside
// the size passes FIND_SEL (ram read) and then FIND_CMP (compare-and-add), one
// that falls outside passes FIND_SEL only.
// The single ram read port, with its registered read, sets these steps.
// Reset: the tree is cleared by a pass over all 4096 entries, one per cycle,
// with busy high throughout; csr writes are taken during the pass.
// csr_we writes size_in_use (reset 4096) and should be used only while idle.
module fenwick_kth_order_statistic_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fkos_pkg::req_item_type       req_item,
   output logic                         rsp_strobe,
   output fkos_pkg::rsp_item_type       rsp_item,
   input  logic                         csr_we,
   input  logic [fkos_pkg::SIZE_W-1:0]  csr_wdata
);

   localparam int ADDR_W  = fkos_pkg::ADDR_W;
   localparam int POS_W   = fkos_pkg::POS_W;
   localparam int LEVEL_W = fkos_pkg::LEVEL_W;
   localparam int CMP_W   = fkos_pkg::CMP_W;
   localparam int SUM_W   = fkos_pkg::SUM_W;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      ADD,
      FIND_SEL,
      FIND_CMP
   } state_type;

   state_type                     state_ff, state_in;
   logic [fkos_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [ADDR_W-1:0]             clear_addr_ff, clear_addr_in;
   logic [LEVEL_W-1:0]            level_ff, level_in;
   logic [POS_W-1:0]              at_ff, at_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [fkos_pkg::RANK_W-1:0]   rank_ff, rank_in;
   logic [CMP_W-1:0]              add_pos_ff, add_pos_in;
   logic [SUM_W-1:0]              delta_ff, delta_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   fkos_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;

   logic [CMP_W-1:0]  eff_size;
   logic [CMP_W-1:0]  req_pos;
   logic [CMP_W-1:0]  cand;
   logic [CMP_W-1:0]  add_next;
   logic [CMP_W-1:0]  found;
   logic [POS_W-1:0]  at_next;
   logic [SUM_W-1:0]  sum_try;
   logic              take_cand;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [SUM_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [SUM_W-1:0]  mem_rdata;

   fkos_ram #(
      .WIDTH (SUM_W),
      .DEPTH (fkos_pkg::MAX_SIZE)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      if (CMP_W'(size_ff) > CMP_W'(fkos_pkg::MAX_SIZE)) begin
         eff_size = CMP_W'(fkos_pkg::MAX_SIZE);
      end else begin
         eff_size = CMP_W'(size_ff);
      end
      req_pos   = CMP_W'(req_item.index_or_rank);
      cand      = CMP_W'(at_ff) + (CMP_W'(1) << level_ff);
      // step to the parent range: add the lowest set bit
      add_next  = add_pos_ff + (add_pos_ff & (~add_pos_ff + CMP_W'(1)));
      sum_try   = sum_ff + mem_rdata;
      take_cand = $signed({sum_try[SUM_W-1], sum_try}) < $signed((SUM_W + 1)'(rank_ff));
      at_next   = take_cand ? POS_W'(cand) : at_ff;
      found     = CMP_W'(at_next) + CMP_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      size_in       = csr_we ? csr_wdata : size_ff;
      clear_addr_in = clear_addr_ff;
      level_in      = level_ff;
      at_in         = at_ff;
      sum_in        = sum_ff;
      rank_in       = rank_ff;
      add_pos_in    = add_pos_ff;
      delta_in      = delta_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      mem_we        = 1'b0;
      mem_waddr     = ADDR_W'(add_pos_ff - CMP_W'(1));
      mem_wdata     = mem_rdata + delta_ff;
      mem_re        = 1'b0;
      mem_raddr     = ADDR_W'(cand - CMP_W'(1));

      unique case (state_ff)
         CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = clear_addr_ff;
            mem_wdata     = '0;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(fkos_pkg::MAX_SIZE - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (start) begin
               rank_in  = req_item.index_or_rank;
               delta_in = SUM_W'(req_item.delta);
               level_in = LEVEL_W'(fkos_pkg::TOP_LEVEL);
               at_in    = '0;
               sum_in   = '0;
               if (req_item.req_type == fkos_pkg::REQ_FIND) begin
                  state_in = FIND_SEL;
               end else if (req_pos != '0 && req_pos <= eff_size) begin
                  add_pos_in = req_pos;
                  mem_re     = 1'b1;
                  mem_raddr  = ADDR_W'(req_pos - CMP_W'(1));
                  state_in   = ADD;
               end
            end
         end
         ADD: begin
            // write this level and read the next in the same cycle
            mem_we     = 1'b1;
            add_pos_in = add_next;
            if (add_next <= eff_size) begin
               mem_re    = 1'b1;
               mem_raddr = ADDR_W'(add_next - CMP_W'(1));
            end else begin
               state_in = IDLE;
            end
         end
         FIND_SEL: begin
            if (cand <= eff_size) begin
               mem_re   = 1'b1;
               state_in = FIND_CMP;
            end else if (level_ff == '0) begin
               rsp_strobe_in              = 1'b1;
               rsp_item_in.found_position = fkos_pkg::FOUND_W'(CMP_W'(at_ff) + CMP_W'(1));
               rsp_item_in.beyond_total   = (CMP_W'(at_ff) + CMP_W'(1)) > eff_size;
               state_in                   = IDLE;
            end else begin
               level_in = level_ff - LEVEL_W'(1);
            end
         end
         FIND_CMP: begin
            at_in = at_next;
            if (take_cand) begin
               sum_in = sum_try;
            end
            if (level_ff == '0) begin
               rsp_strobe_in              = 1'b1;
               rsp_item_in.found_position = fkos_pkg::FOUND_W'(found);
               rsp_item_in.beyond_total   = found > eff_size;
               state_in                   = IDLE;
            end else begin
               level_in = level_ff - LEVEL_W'(1);
               state_in = FIND_SEL;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CLEAR;
         size_ff       <= fkos_pkg::SIZE_W'(4096);
         clear_addr_ff <= '0;
         level_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         clear_addr_ff <= clear_addr_in;
         level_ff      <= level_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      at_ff       <= at_in;
      sum_ff      <= sum_in;
      rank_ff     <= rank_in;
      add_pos_ff  <= add_pos_in;
      delta_ff    <= delta_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // a response is only raised as the search returns to idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   a_rsp_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.found_position != '0)
      else $error("response position zero");

   a_tree_write_owner: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == CLEAR || state_ff == ADD))
      else $error("tree write outside clear or add");

   a_add_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ADD |-> (add_pos_ff != '0 && add_pos_ff <= CMP_W'(fkos_pkg::MAX_SIZE)))
      else $error("add position out of range");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FIND_SEL || state_ff == FIND_CMP)
         |-> level_ff <= LEVEL_W'(fkos_pkg::TOP_LEVEL))
      else $error("search level out of range");

endmodule

// ----- tb/fenwick_kth_order_statistic_unit_tb.sv -----
// self-checking testbench for fenwick_kth_order_statistic_unit: directed and random traffic
// depends on fkos_pkg and the unit; a built-in tree predictor supplies the expected responses
module fenwick_kth_order_statistic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   fkos_pkg::req_item_type        req_item;
   logic                          rsp_strobe;
   fkos_pkg::rsp_item_type        rsp_item;
   logic                          csr_we;
   logic [fkos_pkg::SIZE_W-1:0]   csr_wdata;

   // predictor state: tree of counts and the size register
   logic [fkos_pkg::SUM_W-1:0]    count_tree [1:fkos_pkg::MAX_SIZE];
   logic [fkos_pkg::SIZE_W-1:0]   tree_size;
   int                            count_total;
   fkos_pkg::rsp_item_type        pending_finds [$];
   int                            error_count;
   bit                            gaps_on;

   fenwick_kth_order_statistic_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int active_size();
      return (tree_size > fkos_pkg::MAX_SIZE) ? fkos_pkg::MAX_SIZE : int'(tree_size);
   endfunction

   function automatic void tree_apply_add(input int pos,
                                          input logic signed [fkos_pkg::DELTA_W-1:0] amount);
      int                          n;
      logic [fkos_pkg::SUM_W-1:0]  wide;
      n = active_size();
      wide = {{(fkos_pkg::SUM_W-fkos_pkg::DELTA_W){amount[fkos_pkg::DELTA_W-1]}}, amount};
      if (pos >= 1 && pos <= n)
         count_total += int'(amount);
      while (pos >= 1 && pos <= n) begin
         count_tree[pos] = count_tree[pos] + wide;
         pos = pos + (pos & -pos);
      end
   endfunction

   function automatic fkos_pkg::rsp_item_type tree_locate_rank(input int rank);
      int                          n;
      int                          at;
      int                          cand;
      logic [fkos_pkg::SUM_W-1:0]  sum;
      logic [fkos_pkg::SUM_W-1:0]  trial;
      int                          trial_s;
      fkos_pkg::rsp_item_type      res;
      n = active_size();
      at = 0;
      sum = '0;
      for (int level = fkos_pkg::TOP_LEVEL; level >= 0; level--) begin
         cand = at + (1 << level);
         if (cand <= n) begin
            trial = sum + count_tree[cand];
            trial_s = trial;
            if (trial_s < rank) begin
               at = cand;
               sum = trial;
            end
         end
      end
      res.found_position = fkos_pkg::FOUND_W'(at + 1);
      res.beyond_total   = (at + 1 > n);
      return res;
   endfunction

   // response checker
   always @(posedge clock) begin
      fkos_pkg::rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_finds.size() == 0) begin
            $display("%0t: response with none expected, found_position %0d beyond_total %0d",
                     $time, rsp_item.found_position, rsp_item.beyond_total);
            error_count++;
         end else begin
            want = pending_finds.pop_front();
            if (rsp_item.found_position !== want.found_position) begin
               $display("%0t: found_position expected %0d actual %0d",
                        $time, want.found_position, rsp_item.found_position);
               error_count++;
            end
            if (rsp_item.beyond_total !== want.beyond_total) begin
               $display("%0t: beyond_total expected %0d actual %0d",
                        $time, want.beyond_total, rsp_item.beyond_total);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input logic kind, input logic [fkos_pkg::RANK_W-1:0] arg,
                               input logic signed [fkos_pkg::DELTA_W-1:0] amount);
      fkos_pkg::req_item_type item;
      item.req_type      = kind;
      item.index_or_rank = arg;
      item.delta         = amount;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      start    = 1'b1;
      req_item = item;
      do @(posedge clock); while (busy);
      // request taken at this edge
      if (kind == fkos_pkg::REQ_ADD)
         tree_apply_add(int'(arg), amount);
      else
         pending_finds.push_back(tree_locate_rank(int'(arg)));
   endtask

   task automatic stop_requests();
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic set_size(input int value);
      stop_requests();
      while (pending_finds.size() != 0) @(negedge clock);
      // adds leave no response, so let any tree walk finish
      repeat (32) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = fkos_pkg::SIZE_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
      tree_size = fkos_pkg::SIZE_W'(value);
   endtask

   task automatic test_empty_tree();
      send_request(fkos_pkg::REQ_FIND, 16'd0, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'd1, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'hFFFF, -16'sd1);
   endtask

   task automatic test_add_bounds();
      send_request(fkos_pkg::REQ_ADD, 16'd0, 16'sd5);
      send_request(fkos_pkg::REQ_ADD, 16'd4097, 16'sd7);
      send_request(fkos_pkg::REQ_ADD, 16'hFFFF, -16'sd1);
      send_request(fkos_pkg::REQ_ADD, 16'd1, 16'sd32767);
      send_request(fkos_pkg::REQ_ADD, 16'd4096, -16'sd32768);
      send_request(fkos_pkg::REQ_ADD, 16'd2048, 16'sd3);
      send_request(fkos_pkg::REQ_FIND, 16'd32767, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'd32768, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'd0, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'hFFFF, 16'sd0);
   endtask

   task automatic test_size_extremes();
      set_size(0);
      send_request(fkos_pkg::REQ_ADD, 16'd1, 16'sd1);
      send_request(fkos_pkg::REQ_FIND, 16'd0, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'd5, 16'sd0);
      set_size(8191);
      send_request(fkos_pkg::REQ_FIND, 16'd1, 16'sd0);
      send_request(fkos_pkg::REQ_ADD, 16'd4096, 16'sd1);
      send_request(fkos_pkg::REQ_FIND, 16'd32770, 16'sd0);
      set_size(4097);
      send_request(fkos_pkg::REQ_FIND, 16'hFFFF, 16'sd0);
   endtask

   task automatic test_size_change();
      set_size(4);
      send_request(fkos_pkg::REQ_ADD, 16'd3, 16'sd2);
      // grown tree: entry 8 never saw the add at 3
      set_size(8);
      send_request(fkos_pkg::REQ_ADD, 16'd5, 16'sd1);
      send_request(fkos_pkg::REQ_FIND, 16'd3, 16'sd0);
      send_request(fkos_pkg::REQ_FIND, 16'd4, 16'sd0);
      set_size(1);
      send_request(fkos_pkg::REQ_FIND, 16'd1, 16'sd0);
   endtask

   task automatic test_random_traffic(input int size_value, input int count, input bit with_gaps);
      int                                  pick;
      int                                  n;
      int                                  pos;
      int                                  rank_top;
      logic signed [fkos_pkg::DELTA_W-1:0] amount;
      set_size(size_value);
      gaps_on = with_gaps;
      n = active_size();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // noise: any field value
            send_request(logic'($urandom_range(0, 1)), fkos_pkg::RANK_W'($urandom()),
                         fkos_pkg::DELTA_W'($urandom()));
         end else if (pick < 56) begin
            pos = $urandom_range(1, n);
            if ($urandom_range(0, 9) == 0)
               amount = -fkos_pkg::DELTA_W'($urandom_range(1, 3));
            else
               amount = fkos_pkg::DELTA_W'($urandom_range(1, 4));
            send_request(fkos_pkg::REQ_ADD, fkos_pkg::RANK_W'(pos), amount);
         end else begin
            rank_top = (count_total < 0) ? 2 : count_total + 2;
            if (rank_top > 65535)
               rank_top = 65535;
            send_request(fkos_pkg::REQ_FIND, fkos_pkg::RANK_W'($urandom_range(0, rank_top)),
                         fkos_pkg::DELTA_W'($urandom()));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      tree_size   = fkos_pkg::SIZE_W'(fkos_pkg::MAX_SIZE);
      count_total = 0;
      error_count = 0;
      gaps_on     = 1'b1;
      for (int i = 1; i <= fkos_pkg::MAX_SIZE; i++)
         count_tree[i] = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_empty_tree();
      test_add_bounds();
      test_size_extremes();
      test_size_change();

      test_random_traffic(4096, 170, 1'b1);
      test_random_traffic(1, 150, 1'b1);
      test_random_traffic(2, 150, 1'b1);
      test_random_traffic(37, 170, 1'b1);
      test_random_traffic(4096, 170, 1'b1);
      test_random_traffic(8191, 170, 1'b1);
      test_random_traffic($urandom_range(3, 1500), 170, 1'b1);
      test_random_traffic(513, 170, 1'b0);

      stop_requests();
      while (pending_finds.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
